@@ src/tbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and helpers of the bilinear texel sampler
// Payload structs of both channels, the command queue entry, register
// indexes, sequencer states and the Q0.16 linear blend.
// ----------------------------------------------------------------------------
package tbs_pkg;

  // Widest coordinate any configuration of the block can use.
  localparam int COORD_W = 12;
  localparam int CHAN_W  = 16;
  localparam int NUM_CH  = 4;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic        op;
    logic [7:0]  texel_x;
    logic [7:0]  texel_y;
    logic [15:0] write_ch0;
    logic [15:0] write_ch1;
    logic [15:0] write_ch2;
    logic [15:0] write_ch3;
    logic [16:0] u_coord;
    logic [16:0] v_coord;
    logic [2:0]  channels_wanted;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sample_ch0;
    logic [15:0] sample_ch1;
    logic [15:0] sample_ch2;
    logic [15:0] sample_ch3;
  } out_item_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [3:0] width_log2;
    logic [2:0] channel_count;
  } cfg_t;

  // A write carries its target in x0/y0; a sample carries both corners.
  typedef struct packed {
    cmd_t                           kind;
    logic [COORD_W-1:0]             x0;
    logic [COORD_W-1:0]             x1;
    logic [COORD_W-1:0]             y0;
    logic [COORD_W-1:0]             y1;
    logic [15:0]                    fu;
    logic [15:0]                    fv;
    logic [NUM_CH-1:0]              mask;
    logic [NUM_CH-1:0][CHAN_W-1:0]  data;
  } entry_t;

  typedef enum logic [1:0] {
    SEQ_READY = 2'd0,
    SEQ_T10   = 2'd1,
    SEQ_T01   = 2'd2,
    SEQ_T11   = 2'd3
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_T00 = 2'd0,
    PH_T10 = 2'd1,
    PH_T01 = 2'd2,
    PH_T11 = 2'd3
  } phase_t;

  // (a*(1-f) + b*f) >> 16, rewritten as (a<<16) + (b-a)*f: one multiply.
  function automatic logic [15:0] lerp_q16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] f);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    sum  = $signed({2'b00, a, 16'h0000}) + prod;
    return sum[31:16];
  endfunction

endpackage

@@ src/tbs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_front: input acceptance and classification
// Drops out-of-range writes, splits sample coordinates into corners and
// fractions and builds the channel mask for the back end.
// ----------------------------------------------------------------------------
module tbs_front import tbs_pkg::*; #(
  parameter int MAX_WIDTH_LOG2 = 8
) (
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output entry_t   push_entry
);

  localparam int MW = MAX_WIDTH_LOG2;
  localparam int GW = MW + 17;

  logic [MW-1:0] side_m1;
  logic [16:0]   u_sat, v_sat;
  logic [GW-1:0] gu, gv;
  logic [MW-1:0] x0, x1, y0, y1;
  logic          in_range;
  logic          keep;

  always_comb begin
    side_m1 = MW'((32'd1 << cfg.width_log2) - 32'd1);
    u_sat   = (in_data.u_coord > ONE_Q16) ? ONE_Q16 : in_data.u_coord;
    v_sat   = (in_data.v_coord > ONE_Q16) ? ONE_Q16 : in_data.v_coord;
    gu      = GW'(side_m1) * GW'(u_sat);
    gv      = GW'(side_m1) * GW'(v_sat);
    // Product never exceeds side-1 in its integer part.
    x0      = gu[MW+15:16];
    y0      = gv[MW+15:16];
    x1      = (x0 == side_m1) ? x0 : x0 + 1'b1;
    y1      = (y0 == side_m1) ? y0 : y0 + 1'b1;
  end

  assign in_range = ((32'(in_data.texel_x) >> cfg.width_log2) == 32'd0) &&
                    ((32'(in_data.texel_y) >> cfg.width_log2) == 32'd0);
  assign keep     = in_data.op | in_range;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

  always_comb begin
    push_entry.kind = in_data.op ? CMD_SAMPLE : CMD_WRITE;
    if (in_data.op) begin
      push_entry.x0 = COORD_W'(x0);
      push_entry.y0 = COORD_W'(y0);
    end else begin
      push_entry.x0 = COORD_W'(in_data.texel_x);
      push_entry.y0 = COORD_W'(in_data.texel_y);
    end
    push_entry.x1 = COORD_W'(x1);
    push_entry.y1 = COORD_W'(y1);
    push_entry.fu = gu[15:0];
    push_entry.fv = gv[15:0];
    for (int k = 0; k < NUM_CH; k++) begin
      push_entry.mask[k] = (3'(k) < in_data.channels_wanted) && (3'(k) < cfg.channel_count);
    end
    push_entry.data[0] = in_data.write_ch0;
    push_entry.data[1] = in_data.write_ch1;
    push_entry.data[2] = in_data.write_ch2;
    push_entry.data[3] = in_data.write_ch3;
  end

endmodule

@@ src/tbs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_queue: command queue between front and back
// Small register FIFO so that intake and texel fetch stall independently.
// ----------------------------------------------------------------------------
module tbs_queue import tbs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("queue pop while empty");

endmodule

@@ src/tbs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_back: texel memory, fetch sequencer and blend pipeline
// Writes take one memory access; a sample fetches four corners in the order
// T00, T10, T01, T11 and blends all channels side by side.
// ----------------------------------------------------------------------------
module tbs_back import tbs_pkg::*; #(
  parameter int MAX_WIDTH_LOG2 = 8,
  parameter int MAX_CHANNELS   = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  entry_t    q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int MW    = MAX_WIDTH_LOG2;
  localparam int AW    = 2 * MW;
  localparam int DEPTH = 1 << AW;
  localparam int MEM_W = CHAN_W * MAX_CHANNELS;

  typedef struct packed {
    logic              valid;
    phase_t            phase;
    logic [15:0]       fu;
    logic [15:0]       fv;
    logic [NUM_CH-1:0] mask;
  } fetch_t;

  logic [MEM_W-1:0] mem [DEPTH];
  logic [MEM_W-1:0] rd_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_addr;

  seq_state_t state_r, state_nxt;
  entry_t     cur_r;
  fetch_t     iss, p1_r;
  logic       adv;

  logic [NUM_CH-1:0][CHAN_W-1:0] rd_ch;
  logic [NUM_CH-1:0][CHAN_W-1:0] a_r, top_r, bot_r;
  logic                          p2_valid_r;
  logic [15:0]                   p2_fv_r;
  logic [NUM_CH-1:0]             p2_mask_r;
  logic                          out_valid_r;
  logic [NUM_CH-1:0][CHAN_W-1:0] res_r;
  logic [NUM_CH-1:0][CHAN_W-1:0] res_nxt;

  // Whole back end freezes while a finished result waits at the output.
  assign adv = !(out_valid_r && out_stall);

  // ---- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_READY: if (adv && q_valid && q_entry.kind == CMD_SAMPLE) state_nxt = SEQ_T10;
      SEQ_T10:   if (adv) state_nxt = SEQ_T01;
      SEQ_T01:   if (adv) state_nxt = SEQ_T11;
      SEQ_T11:   if (adv) state_nxt = SEQ_READY;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {cur_r.y0[MW-1:0], cur_r.x0[MW-1:0]};
    iss.valid = 1'b0;
    iss.phase = PH_T00;
    iss.fu    = cur_r.fu;
    iss.fv    = cur_r.fv;
    iss.mask  = cur_r.mask;
    unique case (state_r)
      SEQ_READY: begin
        q_pop     = adv && q_valid;
        mem_we    = q_pop && (q_entry.kind == CMD_WRITE);
        mem_re    = q_pop && (q_entry.kind == CMD_SAMPLE);
        mem_addr  = {q_entry.y0[MW-1:0], q_entry.x0[MW-1:0]};
        iss.valid = mem_re;
        iss.fu    = q_entry.fu;
        iss.fv    = q_entry.fv;
        iss.mask  = q_entry.mask;
      end
      SEQ_T10: begin
        mem_re    = adv;
        mem_addr  = {cur_r.y0[MW-1:0], cur_r.x1[MW-1:0]};
        iss.valid = adv;
        iss.phase = PH_T10;
      end
      SEQ_T01: begin
        mem_re    = adv;
        mem_addr  = {cur_r.y1[MW-1:0], cur_r.x0[MW-1:0]};
        iss.valid = adv;
        iss.phase = PH_T01;
      end
      SEQ_T11: begin
        mem_re    = adv;
        mem_addr  = {cur_r.y1[MW-1:0], cur_r.x1[MW-1:0]};
        iss.valid = adv;
        iss.phase = PH_T11;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_READY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_entry;
  end

  // ---- texel memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= MEM_W'(q_entry.data);
    if (mem_re) rd_r <= mem[mem_addr];
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    if (k < MAX_CHANNELS) begin : g_held
      assign rd_ch[k] = rd_r[k*CHAN_W +: CHAN_W];
    end else begin : g_absent
      assign rd_ch[k] = '0;
    end
  end

  // ---- blend pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
      p2_valid_r <= 1'b0;
    end else if (adv) begin
      p1_r       <= iss;
      p2_valid_r <= p1_r.valid && (p1_r.phase == PH_T11);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p1_r.valid) begin
        unique case (p1_r.phase)
          PH_T00: a_r <= rd_ch;
          PH_T10: begin
            for (int k = 0; k < NUM_CH; k++) top_r[k] <= lerp_q16(a_r[k], rd_ch[k], p1_r.fu);
          end
          PH_T01: a_r <= rd_ch;
          PH_T11: begin
            for (int k = 0; k < NUM_CH; k++) bot_r[k] <= lerp_q16(a_r[k], rd_ch[k], p1_r.fu);
            p2_fv_r   <= p1_r.fv;
            p2_mask_r <= p1_r.mask;
          end
        endcase
      end
    end
  end

  // ---- output register
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      res_nxt[k] = p2_mask_r[k] ? lerp_q16(top_r[k], bot_r[k], p2_fv_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p2_valid_r) res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_data.sample_ch0 = res_r[0];
  assign out_data.sample_ch1 = res_r[1];
  assign out_data.sample_ch2 = res_r[2];
  assign out_data.sample_ch3 = res_r[3];

  a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
      (adv && p1_r.valid && p1_r.phase == PH_T00) |=> (p1_r.valid && p1_r.phase == PH_T10))
    else $error("corner fetch out of order");
  a_blend_done: assert property (@(posedge clk) disable iff (!rst_n)
      (adv && p1_r.valid && p1_r.phase == PH_T11) |=> p2_valid_r)
    else $error("last corner did not reach final blend");
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r != SEQ_READY) |-> (!q_pop && !mem_we))
    else $error("memory write or pop during sample fetch");

endmodule

@@ src/bilinear_texel_sampler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texel_sampler_core: bilinear sampler over a square texel store
// Holds a power-of-two texture of up to four 16-bit channels and returns the
// Q0.16 bilinear blend of the four corners around a sample coordinate.
// ----------------------------------------------------------------------------
// Write items store one texel and give no result; writes outside the current
// texture side are dropped. Sample items give one result each. The front
// end takes one item per cycle while the four-entry command queue has room.
// The back end is bound by the single-port texel memory: a write holds the
// port for one access, a sample for four (one per corner texel), so a sample
// holds off the next item until its last corner is read; writes go one per
// cycle unless the output stalls. Results leave through an output register.
// All channels are blended side by side; each blend step truncates once.
// Reading a texel that was never written gives an unspecified value, since
// the store is not cleared at reset. Write configuration only while idle.
// ----------------------------------------------------------------------------
module bilinear_texel_sampler_core import tbs_pkg::*; #(
  parameter int MAX_WIDTH_LOG2 = 8,
  parameter int MAX_CHANNELS   = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [3:0] width_log2_r;
  logic [2:0] channel_count_r;
  cfg_t       cfg_eff;

  logic   push, q_full, q_pop, q_valid;
  entry_t push_entry, q_entry;

  // Registers are always writable; a transfer to an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r    <= 4'd8;
      channel_count_r <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH_LOG2:    width_log2_r    <= cfg_data[3:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers into the range this build supports.
  always_comb begin
    priority if (width_log2_r == 4'd0) cfg_eff.width_log2 = 4'd1;
    else if (width_log2_r > 4'(MAX_WIDTH_LOG2)) cfg_eff.width_log2 = 4'(MAX_WIDTH_LOG2);
    else cfg_eff.width_log2 = width_log2_r;

    priority if (channel_count_r == 3'd0) cfg_eff.channel_count = 3'd1;
    else if (channel_count_r > 3'(MAX_CHANNELS)) cfg_eff.channel_count = 3'(MAX_CHANNELS);
    else cfg_eff.channel_count = channel_count_r;
  end

  // Front: classify and split coordinates.
  tbs_front #(
    .MAX_WIDTH_LOG2(MAX_WIDTH_LOG2)
  ) u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg       (cfg_eff),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  // Queue: decouple intake from memory access.
  tbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_entry   (q_entry)
  );

  // Back: texel memory, corner fetch, blend and output register.
  tbs_back #(
    .MAX_WIDTH_LOG2(MAX_WIDTH_LOG2),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ test/bilinear_texel_sampler_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texel_sampler_core_tb: self-checking bench for the texel sampler
// Loads texels, requests bilinear samples and checks every result against a
// typed value or a local Q0.16 blend from a shadow copy of the texel store.
// Runs a short table of hand-picked items, then random traffic over several
// texture sizes and channel counts, with random gaps on both channels.
// ----------------------------------------------------------------------------
module bilinear_texel_sampler_core_tb;
  import tbs_pkg::*;

  localparam int SIDE_LOG2_MAX = 8;     // matches the default MAX_WIDTH_LOG2
  localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES = 24;    // lets queued writes retire before config changes
  localparam int MAX_REPORTS   = 10;
  localparam int SEG_ITEMS     = 50;
  localparam int NUM_SEGS      = 8;

  typedef struct {
    in_item_t  item;
    bit        typed;    // result typed in by hand rather than computed
    out_item_t result;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the block: raw register values and the texel store.
  logic [3:0]        width_reg;
  logic [2:0]        chan_reg;
  logic [3:0][15:0]  texel_mem [0:65535];
  bit                texel_written [0:65535];

  out_item_t  blend_queue[$];   // expected sample results, oldest first
  out_item_t  oldest_blend;
  plan_row_t  plan[$];
  int         error_count;
  int         quiet_cycles;
  int         landed_items;     // writes that hit the texture plus samples
  int         send_idle_pct;
  int         recv_idle_pct;

  logic [3:0] seg_side_log2 [NUM_SEGS] = '{4'd1, 4'd0, 4'd2, 4'd15, 4'd3, 4'd4, 4'd9, 4'd5};
  logic [3:0] seg_chans     [NUM_SEGS] = '{4'd1, 4'd0, 4'd3, 4'd2, 4'd13, 4'd4, 4'd7, 4'd2};

  bilinear_texel_sampler_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Blend prediction
  // --------------------------------------------------------------------------

  // Texture side after clamping the width register into 1..SIDE_LOG2_MAX.
  function automatic int unsigned texture_side();
    int unsigned l;
    l = 32'(width_reg);
    if (l < 1) l = 1;
    if (l > SIDE_LOG2_MAX) l = SIDE_LOG2_MAX;
    return 1 << l;
  endfunction

  function automatic int unsigned held_channels();
    int unsigned c;
    c = 32'(chan_reg);
    if (c < 1) c = 1;
    if (c > 4) c = 4;
    return c;
  endfunction

  // The store is laid out for the largest side, whatever the current width.
  function automatic logic [15:0] texel_addr(input int unsigned x, input int unsigned y);
    return {y[7:0], x[7:0]};
  endfunction

  // Scale a Q1.16 coordinate by side-1; split into near corner, far corner
  // (clamped to the last texel) and blend fraction. Saturate above 1.0.
  function automatic void split_axis(input logic [16:0] coord, input int unsigned side,
                                     output int unsigned lo, output int unsigned hi,
                                     output logic [15:0] frac);
    longint unsigned c;
    longint unsigned scaled;
    c = 64'(coord);
    if (c > 65536) c = 65536;
    scaled = longint'(side - 1) * c;
    lo = 32'(scaled >> 16);
    if (lo > side - 1) lo = side - 1;
    hi = (lo + 1 > side - 1) ? side - 1 : lo + 1;
    frac = scaled[15:0];
  endfunction

  // One linear step, truncated once.
  function automatic logic [15:0] blend_q16(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] f);
    longint unsigned acc;
    acc = longint'(a) * (65536 - longint'(f)) + longint'(b) * longint'(f);
    return acc[31:16];
  endfunction

  function automatic out_item_t predict_blend(input in_item_t it);
    int unsigned      side;
    int unsigned      x0, x1, y0, y1;
    int unsigned      wanted;
    int unsigned      held;
    logic [15:0]      fu, fv;
    logic [3:0][15:0] t00, t10, t01, t11;
    logic [3:0][15:0] res;
    out_item_t        o;
    side = texture_side();
    split_axis(it.u_coord, side, x0, x1, fu);
    split_axis(it.v_coord, side, y0, y1, fv);
    wanted = 32'(it.channels_wanted);
    if (wanted > 4) wanted = 4;
    held = held_channels();
    t00 = texel_mem[texel_addr(x0, y0)];
    t10 = texel_mem[texel_addr(x1, y0)];
    t01 = texel_mem[texel_addr(x0, y1)];
    t11 = texel_mem[texel_addr(x1, y1)];
    res = '0;
    for (int k = 0; k < 4; k++) begin
      if (k < wanted && k < held) begin
        res[k] = blend_q16(blend_q16(t00[k], t10[k], fu), blend_q16(t01[k], t11[k], fu), fv);
      end
    end
    o.sample_ch0 = res[0];
    o.sample_ch1 = res[1];
    o.sample_ch2 = res[2];
    o.sample_ch3 = res[3];
    return o;
  endfunction

  // Update the shadow on an accepted input transfer. Drop writes outside the
  // current texture; queue the result of every sample.
  task automatic note_transfer(input in_item_t it, input bit typed, input out_item_t res);
    int unsigned side;
    logic [15:0] a;
    side = texture_side();
    if (it.op == CMD_WRITE) begin
      if (it.texel_x < side && it.texel_y < side) begin
        a = texel_addr(it.texel_x, it.texel_y);
        texel_mem[a] = {it.write_ch3, it.write_ch2, it.write_ch1, it.write_ch0};
        texel_written[a] = 1'b1;
        landed_items++;
      end
    end else begin
      blend_queue.insert(blend_queue.size(), typed ? res : predict_blend(it));
      landed_items++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Item construction
  // --------------------------------------------------------------------------

  function automatic in_item_t texel_write(input int unsigned x, input int unsigned y,
                                           input logic [15:0] c0, input logic [15:0] c1,
                                           input logic [15:0] c2, input logic [15:0] c3);
    in_item_t it;
    it = '0;
    it.op        = CMD_WRITE;
    it.texel_x   = x[7:0];
    it.texel_y   = y[7:0];
    it.write_ch0 = c0;
    it.write_ch1 = c1;
    it.write_ch2 = c2;
    it.write_ch3 = c3;
    return it;
  endfunction

  function automatic in_item_t sample_at(input logic [16:0] u, input logic [16:0] v,
                                         input logic [2:0] wanted);
    in_item_t it;
    it = '0;
    it.op              = CMD_SAMPLE;
    it.u_coord         = u;
    it.v_coord         = v;
    it.channels_wanted = wanted;
    return it;
  endfunction

  function automatic out_item_t blend_of(input logic [15:0] c0, input logic [15:0] c1,
                                         input logic [15:0] c2, input logic [15:0] c3);
    out_item_t o;
    o.sample_ch0 = c0;
    o.sample_ch1 = c1;
    o.sample_ch2 = c2;
    o.sample_ch3 = c3;
    return o;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input in_item_t it, input bit typed, input out_item_t res);
    plan_row_t row;
    row.item   = it;
    row.typed  = typed;
    row.result = res;
    plan.insert(plan.size(), row);
  endtask

  // Favor the edges of the unit range and the saturating region above 1.0.
  function automatic logic [16:0] pick_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 17'd0;
    if (r < 16) return ONE_Q16;
    if (r < 22) return 17'($urandom_range(131071, 65537));
    return 17'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] pick_channel();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Idle first at the
  // current sender rate; valid stays high between back-to-back transfers.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    note_transfer(it, typed, res);
  endtask

  task automatic send_texel(input in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Write a texel somewhere inside the texture, or now and then anywhere in
  // the 8-bit range so that some writes fall outside and get dropped.
  task automatic random_texel(input bit stray);
    in_item_t it;
    int unsigned side;
    side = texture_side();
    it = texel_write(stray ? $urandom_range(255) : $urandom_range(side - 1),
                     stray ? $urandom_range(255) : $urandom_range(side - 1),
                     pick_channel(), pick_channel(), pick_channel(), pick_channel());
    it.u_coord         = 17'($urandom);
    it.v_coord         = 17'($urandom);
    it.channels_wanted = 3'($urandom);
    send_texel(it);
  endtask

  // Fill any corner that was never written, then request the sample: the
  // block must never read an unwritten texel.
  task automatic random_sample();
    in_item_t    it;
    int unsigned side;
    int unsigned x0, x1, y0, y1;
    logic [15:0] fu, fv;
    side = texture_side();
    it = sample_at(pick_coord(), pick_coord(),
                   ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1)));
    it.texel_x   = 8'($urandom);
    it.texel_y   = 8'($urandom);
    it.write_ch0 = 16'($urandom);
    it.write_ch1 = 16'($urandom);
    it.write_ch2 = 16'($urandom);
    it.write_ch3 = 16'($urandom);
    split_axis(it.u_coord, side, x0, x1, fu);
    split_axis(it.v_coord, side, y0, y1, fv);
    if (!texel_written[texel_addr(x0, y0)])
      send_texel(texel_write(x0, y0, pick_channel(), pick_channel(), pick_channel(), pick_channel()));
    if (!texel_written[texel_addr(x1, y0)])
      send_texel(texel_write(x1, y0, pick_channel(), pick_channel(), pick_channel(), pick_channel()));
    if (!texel_written[texel_addr(x0, y1)])
      send_texel(texel_write(x0, y1, pick_channel(), pick_channel(), pick_channel(), pick_channel()));
    if (!texel_written[texel_addr(x1, y1)])
      send_texel(texel_write(x1, y1, pick_channel(), pick_channel(), pick_channel(), pick_channel()));
    send_item(it, 1'b0, '0);
  endtask

  // Hold off the sender until every sample has come back, then give queued
  // writes (which never answer) time to retire.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (blend_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high across the pair.
  task automatic write_config(input logic [3:0] side_log2, input logic [3:0] chans);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIDTH_LOG2;
    cfg_data  <= side_log2;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = side_log2;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= chans;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chan_reg = chans[2:0];
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------

  // Values read here are the ones before the edge, so a transfer seen here
  // happened at this edge. Draw the next stall only after the check.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (blend_queue.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected sample result %h", $realtime, out_data);
      end else begin
        oldest_blend = blend_queue.pop_front();
        if (out_data.sample_ch0 !== oldest_blend.sample_ch0 ||
            out_data.sample_ch1 !== oldest_blend.sample_ch1 ||
            out_data.sample_ch2 !== oldest_blend.sample_ch2 ||
            out_data.sample_ch3 !== oldest_blend.sample_ch3) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: sample mismatch, expected %h %h %h %h, got %h %h %h %h",
                     $realtime, oldest_blend.sample_ch0, oldest_blend.sample_ch1,
                     oldest_blend.sample_ch2, oldest_blend.sample_ch3,
                     out_data.sample_ch0, out_data.sample_ch1,
                     out_data.sample_ch2, out_data.sample_ch3);
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: end the run if nothing transfers on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int          seg_start;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    width_reg     = 4'd8;
    chan_reg      = 3'd4;
    error_count   = 0;
    landed_items  = 0;
    send_idle_pct = 19;
    recv_idle_pct = 67;

    // Directed table, run at the reset configuration (side 256, four channels).
    // Texels around the origin carry the channel extremes.
    add_row(texel_write(0, 0, 16'hFFFF, 16'h0000, 16'h1234, 16'h8000), 1'b0, '0);
    add_row(texel_write(1, 0, 16'h0000, 16'hFFFF, 16'h5678, 16'h7FFF), 1'b0, '0);
    add_row(texel_write(0, 1, 16'hAAAA, 16'h5555, 16'h0001, 16'hFFFE), 1'b0, '0);
    add_row(texel_write(1, 1, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000), 1'b0, '0);
    // Far corner: both coordinates at one, and above one, land only here.
    add_row(texel_write(255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0);
    // Neighborhood of the texture center.
    add_row(texel_write(127, 127, 16'h0100, 16'hF00F, 16'h8001, 16'h3C3C), 1'b0, '0);
    add_row(texel_write(128, 127, 16'hFF00, 16'h0FF0, 16'h7FFE, 16'hC3C3), 1'b0, '0);
    add_row(texel_write(127, 128, 16'h1357, 16'h2468, 16'hFFFF, 16'h0000), 1'b0, '0);
    add_row(texel_write(128, 128, 16'h9BDF, 16'hACE0, 16'h0000, 16'hFFFF), 1'b0, '0);
    // Zero fraction at the origin returns the origin texel as it is.
    add_row(sample_at(17'd0, 17'd0, 3'd4), 1'b1,
            blend_of(16'hFFFF, 16'h0000, 16'h1234, 16'h8000));
    // More channels wanted than exist acts as all four.
    add_row(sample_at(17'd0, 17'd0, 3'd7), 1'b1,
            blend_of(16'hFFFF, 16'h0000, 16'h1234, 16'h8000));
    add_row(sample_at(17'd0, 17'd0, 3'd1), 1'b1,
            blend_of(16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    // No channels wanted: every field zero.
    add_row(sample_at(17'd0, 17'd0, 3'd0), 1'b1, blend_of(16'h0, 16'h0, 16'h0, 16'h0));
    add_row(sample_at(ONE_Q16, ONE_Q16, 3'd4), 1'b1,
            blend_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // Coordinates above one saturate to one.
    add_row(sample_at(17'h1FFFF, 17'h1FFFF, 3'd4), 1'b1,
            blend_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // Nonzero fractions: computed.
    add_row(sample_at(17'd256, 17'd257, 3'd4), 1'b0, '0);
    add_row(sample_at(17'h08000, 17'h08000, 3'd4), 1'b0, '0);
    add_row(sample_at(17'h08000, 17'h08000, 3'd3), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].result);
    wait_drained();

    // Random traffic, one configuration per segment. Idling goes from a slow
    // receiver, to a slow sender, to no idling at all.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg == 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 19;
      end else if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_config(seg_side_log2[seg], seg_chans[seg]);
      seg_start = landed_items;
      while (landed_items - seg_start < SEG_ITEMS) begin
        r = $urandom_range(99);
        if (r < 55) random_sample();
        else random_texel(r >= 88);
      end
      wait_drained();
    end

    if (blend_queue.size() != 0)
      $display("%0d sample results never arrived", blend_queue.size());
    if (error_count == 0 && blend_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
